// ----- rtl/sn3d_pkg.sv -----
// ============================================================================
// sn3d_pkg
// Shared types, constants and helper functions for the 3D simplex noise block.
// ============================================================================
package sn3d_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);

    // Divide-by-three through a reciprocal: floor(u * RECIP3 / 2^33) is exact below 2^32.
    localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
    localparam logic [31:0] DIV_BIAS  = 32'd1610612736;  // 3 * 2^29
    localparam logic [31:0] DIV_QBIAS = 32'd536870912;   // 2^29

    localparam logic [29:0] WEIGHT_Q30 = 30'd644245094;  // 0.6 in Q30

    typedef struct packed {
        logic [3:0]         grad;
        logic signed [31:0] nz;
        logic signed [31:0] ny;
        logic signed [31:0] nx;
    } corner_t;

    typedef corner_t [3:0] item_t;

    localparam logic [7:0] PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [3:0] mod12(logic [7:0] h);
        logic [7:0] v;
        v = h;
        if (v >= 8'd192) v = v - 8'd192;
        if (v >= 8'd96)  v = v - 8'd96;
        if (v >= 8'd48)  v = v - 8'd48;
        if (v >= 8'd24)  v = v - 8'd24;
        if (v >= 8'd12)  v = v - 8'd12;
        return v[3:0];
    endfunction

    function automatic logic signed [33:0] grad_dot(logic [3:0] g, logic signed [31:0] a,
                                                    logic signed [31:0] b, logic signed [31:0] c);
        logic signed [33:0] xa;
        logic signed [33:0] xb;
        logic signed [33:0] xc;
        logic signed [33:0] d;
        xa = 34'(a);
        xb = 34'(b);
        xc = 34'(c);
        unique case (g)
            4'd0:    d =  xa + xb;
            4'd1:    d = -xa + xb;
            4'd2:    d =  xa - xb;
            4'd3:    d = -xa - xb;
            4'd4:    d =  xa + xc;
            4'd5:    d = -xa + xc;
            4'd6:    d =  xa - xc;
            4'd7:    d = -xa - xc;
            4'd8:    d =  xb + xc;
            4'd9:    d = -xb + xc;
            4'd10:   d =  xb - xc;
            4'd11:   d = -xb - xc;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/sn3d_front.sv -----
// ============================================================================
// sn3d_front
// Skews the point, finds the cell and the tetrahedron, hashes the four corners.
// ============================================================================
module sn3d_front #(
    parameter int COORD_FRAC_BITS = sn3d_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [95:0]          in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sn3d_pkg::item_t      out_item
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< COORD_FRAC_BITS;
    localparam int NSTAGE = 7;

    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  vld_next;
    logic               en;

    logic signed [31:0] crd1_reg [3];
    logic [31:0]        u1_reg   [3];
    logic [31:0]        u1_next  [3];
    logic signed [31:0] crd2_reg [3];
    logic [63:0]        p2_reg   [3];
    logic signed [31:0] crd3_reg [3];
    logic signed [31:0] i3_reg   [3];
    logic signed [31:0] n4_reg   [3];
    logic signed [31:0] n4_next  [3];
    logic signed [31:0] s4;
    logic [7:0]         idx4_reg [3];

    sn3d_pkg::item_t    item5_reg;
    sn3d_pkg::item_t    item5_next;
    logic [7:0]         ai5_reg  [4];
    logic [7:0]         aj5_reg  [4];
    logic [7:0]         h5_reg   [4];
    logic [7:0]         ai5_next [4];
    logic [7:0]         aj5_next [4];
    logic [7:0]         h5_next  [4];
    logic [2:0]         d1;
    logic [2:0]         d2;

    sn3d_pkg::item_t    item6_reg;
    logic [7:0]         ai6_reg  [4];
    logic [7:0]         h6_reg   [4];
    sn3d_pkg::item_t    item7_reg;
    sn3d_pkg::item_t    item7_next;

    assign en        = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTAGE-1];
    assign out_item  = item7_reg;
    assign vld_next  = {vld_reg[NSTAGE-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        logic signed [34:0] num [3];
        logic signed [31:0] xs  [3];
        for (int e = 0; e < 3; e++)
        begin
            xs[e] = $signed(in_data[32*e +: 32]);
        end
        num[0] = (35'(xs[0]) <<< 2) + 35'(xs[1]) + 35'(xs[2]);
        num[1] = (35'(xs[1]) <<< 2) + 35'(xs[0]) + 35'(xs[2]);
        num[2] = (35'(xs[2]) <<< 2) + 35'(xs[0]) + 35'(xs[1]);
        for (int e = 0; e < 3; e++)
        begin
            u1_next[e] = 32'(num[e] >>> COORD_FRAC_BITS) + sn3d_pkg::DIV_BIAS;
        end
    end

    assign s4 = i3_reg[0] + i3_reg[1] + i3_reg[2];

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            n4_next[e] = (crd3_reg[e] * 32'sd6) + ((s4 - i3_reg[e] * 32'sd6) <<< COORD_FRAC_BITS);
        end
    end

    always_comb
    begin
        if (n4_reg[0] >= n4_reg[1])
        begin
            if (n4_reg[1] >= n4_reg[2])
            begin
                d1 = 3'b001;
                d2 = 3'b011;
            end
            else if (n4_reg[0] >= n4_reg[2])
            begin
                d1 = 3'b001;
                d2 = 3'b101;
            end
            else
            begin
                d1 = 3'b100;
                d2 = 3'b101;
            end
        end
        else
        begin
            if (n4_reg[1] < n4_reg[2])
            begin
                d1 = 3'b100;
                d2 = 3'b110;
            end
            else if (n4_reg[0] < n4_reg[2])
            begin
                d1 = 3'b010;
                d2 = 3'b110;
            end
            else
            begin
                d1 = 3'b010;
                d2 = 3'b011;
            end
        end
    end

    always_comb
    begin
        logic signed [31:0] off [4][3];
        logic [2:0]         dv  [4];
        dv[0] = 3'b000;
        dv[1] = d1;
        dv[2] = d2;
        dv[3] = 3'b111;
        for (int e = 0; e < 3; e++)
        begin
            off[0][e] = n4_reg[e];
            off[1][e] = d1[e] ? n4_reg[e] - ONE * 32'sd5 : n4_reg[e] + ONE;
            off[2][e] = d2[e] ? n4_reg[e] - ONE * 32'sd4 : n4_reg[e] + ONE * 32'sd2;
            off[3][e] = n4_reg[e] - ONE * 32'sd3;
        end
        for (int c = 0; c < 4; c++)
        begin
            item5_next[c].nx   = off[c][0];
            item5_next[c].ny   = off[c][1];
            item5_next[c].nz   = off[c][2];
            item5_next[c].grad = '0;
            ai5_next[c] = idx4_reg[0] + 8'(dv[c][0]);
            aj5_next[c] = idx4_reg[1] + 8'(dv[c][1]);
            h5_next[c]  = sn3d_pkg::PERM[idx4_reg[2] + 8'(dv[c][2])];
        end
    end

    always_comb
    begin
        item7_next = item6_reg;
        for (int c = 0; c < 4; c++)
        begin
            item7_next[c].grad = sn3d_pkg::mod12(sn3d_pkg::PERM[ai6_reg[c] + h6_reg[c]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 3; e++)
            begin
                crd1_reg[e] <= $signed(in_data[32*e +: 32]);
                u1_reg[e]   <= u1_next[e];
                crd2_reg[e] <= crd1_reg[e];
                p2_reg[e]   <= 64'(u1_reg[e]) * 64'(sn3d_pkg::RECIP3);
                crd3_reg[e] <= crd2_reg[e];
                i3_reg[e]   <= $signed({1'b0, p2_reg[e][63:33]} - sn3d_pkg::DIV_QBIAS);
                n4_reg[e]   <= n4_next[e];
                idx4_reg[e] <= i3_reg[e][7:0];
            end
            item5_reg <= item5_next;
            item6_reg <= item5_reg;
            item7_reg <= item7_next;
            for (int c = 0; c < 4; c++)
            begin
                ai5_reg[c] <= ai5_next[c];
                aj5_reg[c] <= aj5_next[c];
                h5_reg[c]  <= h5_next[c];
                ai6_reg[c] <= ai5_reg[c];
                h6_reg[c]  <= sn3d_pkg::PERM[aj5_reg[c] + h5_reg[c]];
            end
        end
    end

endmodule

// ----- rtl/sn3d_queue.sv -----
// ============================================================================
// sn3d_queue
// Short first-in first-out queue between the front and the back.
// ============================================================================
module sn3d_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  sn3d_pkg::item_t  push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output sn3d_pkg::item_t  pop_item
);

    localparam int AW = sn3d_pkg::QUEUE_AW;

    sn3d_pkg::item_t mem [sn3d_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   wr_next;
    logic [AW-1:0]   rd_reg;
    logic [AW-1:0]   rd_next;
    logic [AW:0]     cnt_reg;
    logic [AW:0]     cnt_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = cnt_reg != (AW+1)'(sn3d_pkg::QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(sn3d_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(sn3d_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/sn3d_corner.sv -----
// ============================================================================
// sn3d_corner
// Eleven-stage pipeline for the contribution of one corner, in Q60.
// ============================================================================
module sn3d_corner #(
    parameter int COORD_FRAC_BITS = sn3d_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  sn3d_pkg::corner_t   corner_in,
    output logic signed [63:0]  contrib
);

    // Offsets are in units of 1/(6*2^F); Q30 is floor((n*2^(SH)+1)/3), SH = 29-F.
    localparam int SH = 29 - COORD_FRAC_BITS;
    localparam logic signed [31:0] T1 = 32'(((2 ** SH) + 1) / 3);
    localparam logic signed [31:0] T2 = 32'(((2 ** (SH + 1)) + 1) / 3);

    logic signed [31:0] n_in   [3];
    logic [31:0]        u1_reg [3];
    logic signed [31:0] n1_reg [3];
    logic [63:0]        p2_reg [3];
    logic signed [31:0] n2_reg [3];
    logic signed [31:0] q3_reg [3];
    logic signed [31:0] n3_reg [3];
    logic [1:0]         r4_reg [3];
    logic signed [31:0] q4_reg [3];
    logic signed [31:0] c5_reg [3];
    logic signed [31:0] c5_next[3];
    logic signed [63:0] sq6_reg[3];
    logic [3:0]         g_reg  [5];
    logic signed [33:0] dot_reg [5];
    logic [33:0]        r2_reg;
    logic [63:0]        r2_sum;
    logic [29:0]        t_reg;
    logic [59:0]        t2_reg;
    logic [59:0]        t4f_reg;
    logic signed [63:0] contrib_reg;

    assign n_in[0] = corner_in.nx;
    assign n_in[1] = corner_in.ny;
    assign n_in[2] = corner_in.nz;
    assign contrib = contrib_reg;
    assign r2_sum  = 64'(sq6_reg[0]) + 64'(sq6_reg[1]) + 64'(sq6_reg[2]);

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            unique case (r4_reg[e])
                2'd1:    c5_next[e] = (q4_reg[e] <<< SH) + T1;
                2'd2:    c5_next[e] = (q4_reg[e] <<< SH) + T2;
                default: c5_next[e] = q4_reg[e] <<< SH;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 3; e++)
            begin
                u1_reg[e]  <= n_in[e] + sn3d_pkg::DIV_BIAS;
                n1_reg[e]  <= n_in[e];
                p2_reg[e]  <= 64'(u1_reg[e]) * 64'(sn3d_pkg::RECIP3);
                n2_reg[e]  <= n1_reg[e];
                q3_reg[e]  <= $signed({1'b0, p2_reg[e][63:33]} - sn3d_pkg::DIV_QBIAS);
                n3_reg[e]  <= n2_reg[e];
                r4_reg[e]  <= 2'(n3_reg[e] - q3_reg[e] * 32'sd3);
                q4_reg[e]  <= q3_reg[e];
                c5_reg[e]  <= c5_next[e];
                sq6_reg[e] <= c5_reg[e] * c5_reg[e];
            end
            g_reg[0] <= corner_in.grad;
            for (int s = 1; s < 5; s++)
            begin
                g_reg[s] <= g_reg[s-1];
            end
            dot_reg[0] <= sn3d_pkg::grad_dot(g_reg[4], c5_reg[0], c5_reg[1], c5_reg[2]);
            for (int s = 1; s < 5; s++)
            begin
                dot_reg[s] <= dot_reg[s-1];
            end
            r2_reg      <= r2_sum[63:30];
            t_reg       <= (r2_reg > 34'(sn3d_pkg::WEIGHT_Q30)) ? '0
                           : 30'(34'(sn3d_pkg::WEIGHT_Q30) - r2_reg);
            t2_reg      <= t_reg * t_reg;
            t4f_reg     <= t2_reg[59:30] * t2_reg[59:30];
            contrib_reg <= $signed({1'b0, t4f_reg[59:30]}) * dot_reg[4];
        end
    end

endmodule

// ----- rtl/sn3d_back.sv -----
// ============================================================================
// sn3d_back
// Runs the four corner pipelines, sums them, rounds and saturates to Q1.15.
// ============================================================================
module sn3d_back #(
    parameter int COORD_FRAC_BITS = sn3d_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sn3d_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_data
);

    localparam int NSTAGE = 13;

    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  vld_next;
    logic               en;
    logic signed [63:0] cc [4];
    logic signed [63:0] acc_reg;
    logic signed [63:0] rnd;
    logic signed [15:0] res_next;
    logic [15:0]        res_reg;

    assign en        = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTAGE-1];
    assign out_data  = res_reg;
    assign vld_next  = {vld_reg[NSTAGE-2:0], in_valid};

    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        sn3d_corner #(
            .COORD_FRAC_BITS (COORD_FRAC_BITS)
        ) u_corner (
            .clk       (clk),
            .en        (en),
            .corner_in (in_item[c]),
            .contrib   (cc[c])
        );
    end

    assign rnd = (acc_reg + (64'sd1 <<< 39)) >>> 40;

    always_comb
    begin
        if (rnd > 64'sd32767)
        begin
            res_next = 16'sd32767;
        end
        else if (rnd < -64'sd32768)
        begin
            res_next = -16'sd32768;
        end
        else
        begin
            res_next = 16'(rnd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= cc[0] + cc[1] + cc[2] + cc[3];
            res_reg <= res_next;
        end
    end

endmodule

// ----- rtl/simplex_noise_3d_top.sv -----
// ============================================================================
// simplex_noise_3d_top
// 3D simplex noise of a signed fixed-point point, result in signed Q1.15.
// ============================================================================
// Channel   Dir  Payload
// s_axis    in   tdata[95:0] = x_coord, y_coord, z_coord
// m_axis    out  tdata[15:0] = noise_value
//
// One request is taken every cycle while the output is not stalled; each passes
// through the 7 front stages, the queue and the 13 back stages.
// The back corner pipelines are the longest part; the throughput is one per cycle without stalls.
// Reset clears only the valid bits and the queue pointers and count.
// A stalled output stops the back; the queue lets the front keep going until full.
module simplex_noise_3d_top #(
    parameter int COORD_FRAC_BITS = sn3d_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // x_coord [31:0], y_coord [63:32], z_coord [95:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // noise_value [15:0]
);

    logic            f_valid;
    logic            f_ready;
    sn3d_pkg::item_t f_item;
    logic            b_valid;
    logic            b_ready;
    sn3d_pkg::item_t b_item;

    sn3d_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    sn3d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item)
    );

    sn3d_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_item   (b_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- rtl/sn3d_checker.sv -----
// ============================================================================
// sn3d_checker
// Port-level checks of the noise block, bound to the top level.
// ============================================================================
module sn3d_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata
);

    localparam logic [5:0] CAPACITY = 6'd24;

    logic [5:0] pend_reg;
    logic [5:0] pend_next;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = s_tvalid && s_tready;
    assign acc_out = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (acc_in && !acc_out)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (acc_out && !acc_in)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 6'd0)
        else $error("result without a pending request");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CAPACITY)
        else $error("more requests in flight than the pipeline holds");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 6'd0 |-> s_tready)
        else $error("empty block refuses a request");

endmodule

bind simplex_noise_3d_top sn3d_checker u_sn3d_checker (.*);
